/* rtl/nnds_pkg.sv */
// Shared constants, types and helpers for the nearest-neighbour RGB downscaler.
`timescale 1ns / 1ps

package nnds_pkg;

   // Largest frame dimension handled by the counters and sums
   localparam int MAX_DIM   = 4096;

   // Configuration register and port widths
   localparam int CFG_W     = 13;
   localparam int CSR_IDX_W = 8;

   // Effective size, position and running-sum widths
   localparam int DIM_W     = $clog2(MAX_DIM + 1);
   localparam int POS_W     = $clog2(MAX_DIM);
   localparam int SUM_W     = $clog2(MAX_DIM * MAX_DIM + 1);
   localparam int CMP_W     = (DIM_W > CFG_W) ? DIM_W : CFG_W;

   localparam int PIX_W     = 8;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_WIDTH  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_HEIGHT = CSR_IDX_W'(3);

   // Register reset values
   localparam logic [CFG_W-1:0] SOURCE_WIDTH_RST  = CFG_W'(1280);
   localparam logic [CFG_W-1:0] SOURCE_HEIGHT_RST = CFG_W'(720);
   localparam logic [CFG_W-1:0] TARGET_WIDTH_RST  = CFG_W'(640);
   localparam logic [CFG_W-1:0] TARGET_HEIGHT_RST = CFG_W'(360);

   // Effective frame geometry, all values in 1..MAX_DIM
   typedef struct packed {
      logic [DIM_W-1:0] src_w;
      logic [DIM_W-1:0] src_h;
      logic [DIM_W-1:0] dst_w;
      logic [DIM_W-1:0] dst_h;
   } geom_type;

   // One source pixel
   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             frame_start;
   } pix_type;

   // One selected output pixel
   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             line_end;
      logic             frame_end;
   } rsp_type;

   // Clamp a size to 1..hi
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CMP_W-1:0] v,
                                                  input logic [CMP_W-1:0] hi);
      logic [CMP_W-1:0] r;
      begin
         if (v == '0) begin
            r = CMP_W'(1);
         end else if (v > hi) begin
            r = hi;
         end else begin
            r = v;
         end
         return DIM_W'(r);
      end
   endfunction

endpackage

/* rtl/nearest_neighbor_rgb_downscaler_core.sv */
// Top level of the streaming nearest-neighbour RGB downscaler.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  pix_red, pix_green, pix_blue, frame_start
//   rsp_      out        rsp_valid / rsp_ready  out_red, out_green, out_blue, line_end,
//                                               frame_end
//   csr_      in         csr_valid / csr_ready  index, data (13 bits)
//
// One request per cycle while req_ready is high; a selected pixel goes to the result
// register that drives rsp_, or to the skid entry while rsp_ stalls. The counters and
// running sums update in the accepting cycle; the hit test is combinational.
// A two-entry output stage (result register plus skid) holds one extra pixel while rsp_
// stalls; req_ready drops only while both entries are full.
// Synchronous reset restores the default geometry and restarts the frame position.
`timescale 1ns / 1ps

module nearest_neighbor_rgb_downscaler_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [nnds_pkg::PIX_W-1:0]       req_pix_red,
   input  logic [nnds_pkg::PIX_W-1:0]       req_pix_green,
   input  logic [nnds_pkg::PIX_W-1:0]       req_pix_blue,
   input  logic                             req_frame_start,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [nnds_pkg::PIX_W-1:0]       rsp_out_red,
   output logic [nnds_pkg::PIX_W-1:0]       rsp_out_green,
   output logic [nnds_pkg::PIX_W-1:0]       rsp_out_blue,
   output logic                             rsp_line_end,
   output logic                             rsp_frame_end,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [nnds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nnds_pkg::CFG_W-1:0]       csr_data
);
   import nnds_pkg::*;

   geom_type geom;
   pix_type  pix;
   rsp_type  sel_rsp;
   rsp_type  out_rsp;
   logic     accept;
   logic     emit;
   logic     has_room;

   assign req_ready = has_room;
   assign accept    = req_valid && has_room;

   assign pix.red         = req_pix_red;
   assign pix.green       = req_pix_green;
   assign pix.blue        = req_pix_blue;
   assign pix.frame_start = req_frame_start;

   // Configuration registers and clamped geometry
   nnds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geom      (geom)
   );

   // Select pixels by running sums
   nnds_sel u_sel (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .pix    (pix),
      .geom   (geom),
      .emit   (emit),
      .rsp    (sel_rsp)
   );

   // Register and skid the selected pixel
   nnds_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && emit),
      .push_data (sel_rsp),
      .has_room  (has_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (out_rsp)
   );

   assign rsp_out_red   = out_rsp.red;
   assign rsp_out_green = out_rsp.green;
   assign rsp_out_blue  = out_rsp.blue;
   assign rsp_line_end  = out_rsp.line_end;
   assign rsp_frame_end = out_rsp.frame_end;

endmodule

/* rtl/nnds_csr.sv */
// Configuration registers and effective frame geometry of the downscaler.
`timescale 1ns / 1ps

module nnds_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [nnds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nnds_pkg::CFG_W-1:0]       csr_data,
   output nnds_pkg::geom_type               geom
);
   import nnds_pkg::*;

   logic [CFG_W-1:0] src_w_ff, src_w_in;
   logic [CFG_W-1:0] src_h_ff, src_h_in;
   logic [CFG_W-1:0] dst_w_ff, dst_w_in;
   logic [CFG_W-1:0] dst_h_ff, dst_h_in;
   logic [DIM_W-1:0] eff_src_w;
   logic [DIM_W-1:0] eff_src_h;

   assign csr_ready = 1'b1;

   // Decode the register write; drop unknown indexes
   always_comb begin
      src_w_in = src_w_ff;
      src_h_in = src_h_ff;
      dst_w_in = dst_w_ff;
      dst_h_in = dst_h_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH:  src_w_in = csr_data;
            CSR_SOURCE_HEIGHT: src_h_in = csr_data;
            CSR_TARGET_WIDTH:  dst_w_in = csr_data;
            CSR_TARGET_HEIGHT: dst_h_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= SOURCE_WIDTH_RST;
         src_h_ff <= SOURCE_HEIGHT_RST;
         dst_w_ff <= TARGET_WIDTH_RST;
         dst_h_ff <= TARGET_HEIGHT_RST;
      end else begin
         src_w_ff <= src_w_in;
         src_h_ff <= src_h_in;
         dst_w_ff <= dst_w_in;
         dst_h_ff <= dst_h_in;
      end
   end

   // Clamp source sizes to 1..MAX_DIM, target sizes to 1..source size
   assign eff_src_w = clamp_dim(CMP_W'(src_w_ff), CMP_W'(MAX_DIM));
   assign eff_src_h = clamp_dim(CMP_W'(src_h_ff), CMP_W'(MAX_DIM));

   assign geom.src_w = eff_src_w;
   assign geom.src_h = eff_src_h;
   assign geom.dst_w = clamp_dim(CMP_W'(dst_w_ff), CMP_W'(eff_src_w));
   assign geom.dst_h = clamp_dim(CMP_W'(dst_h_ff), CMP_W'(eff_src_h));

endmodule

/* rtl/nnds_sel.sv */
// Position counters, running sums and pixel selection of the downscaler.
`timescale 1ns / 1ps

module nnds_sel (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  nnds_pkg::pix_type  pix,
   input  nnds_pkg::geom_type geom,
   output logic               emit,
   output nnds_pkg::rsp_type  rsp
);
   import nnds_pkg::*;

   logic [POS_W-1:0] src_col_ff, src_col_in;
   logic [POS_W-1:0] src_row_ff, src_row_in;
   logic [DIM_W-1:0] out_col_ff, out_col_in;
   logic [DIM_W-1:0] out_row_ff, out_row_in;
   logic [SUM_W-1:0] col_src_sum_ff, col_src_sum_in;
   logic [SUM_W-1:0] col_dst_sum_ff, col_dst_sum_in;
   logic [SUM_W-1:0] row_src_sum_ff, row_src_sum_in;
   logic [SUM_W-1:0] row_dst_sum_ff, row_dst_sum_in;

   // Position seen by this request, after a frame-start restart
   logic [POS_W-1:0] cur_src_col, cur_src_row;
   logic [DIM_W-1:0] cur_out_col, cur_out_row;
   logic [SUM_W-1:0] cur_col_src, cur_col_dst, cur_row_src, cur_row_dst;
   logic             col_hit, row_hit, line_done, frame_done, line_end;

   assign cur_src_col = pix.frame_start ? '0 : src_col_ff;
   assign cur_src_row = pix.frame_start ? '0 : src_row_ff;
   assign cur_out_col = pix.frame_start ? '0 : out_col_ff;
   assign cur_out_row = pix.frame_start ? '0 : out_row_ff;
   assign cur_col_src = pix.frame_start ? '0 : col_src_sum_ff;
   assign cur_col_dst = pix.frame_start ? '0 : col_dst_sum_ff;
   assign cur_row_src = pix.frame_start ? '0 : row_src_sum_ff;
   assign cur_row_dst = pix.frame_start ? '0 : row_dst_sum_ff;

   // A column or row is hit while the next target position still maps onto it
   assign col_hit = (cur_out_col < geom.dst_w) &&
                    (cur_col_dst < cur_col_src + SUM_W'(geom.dst_w));
   assign row_hit = (cur_out_row < geom.dst_h) &&
                    (cur_row_dst < cur_row_src + SUM_W'(geom.dst_h));

   assign line_done  = (DIM_W'(cur_src_col) >= geom.src_w - DIM_W'(1));
   assign frame_done = (DIM_W'(cur_src_row) >= geom.src_h - DIM_W'(1));
   assign line_end   = (cur_out_col == geom.dst_w - DIM_W'(1));

   assign emit          = col_hit && row_hit;
   assign rsp.red       = pix.red;
   assign rsp.green     = pix.green;
   assign rsp.blue      = pix.blue;
   assign rsp.line_end  = line_end;
   assign rsp.frame_end = line_end && (cur_out_row == geom.dst_h - DIM_W'(1));

   // Advance counters and sums; restart at line and frame ends
   always_comb begin
      src_col_in     = cur_src_col;
      src_row_in     = cur_src_row;
      out_col_in     = cur_out_col;
      out_row_in     = cur_out_row;
      col_src_sum_in = cur_col_src;
      col_dst_sum_in = cur_col_dst;
      row_src_sum_in = cur_row_src;
      row_dst_sum_in = cur_row_dst;
      if (col_hit) begin
         out_col_in     = cur_out_col + DIM_W'(1);
         col_dst_sum_in = cur_col_dst + SUM_W'(geom.src_w);
      end
      if (line_done) begin
         src_col_in     = '0;
         out_col_in     = '0;
         col_src_sum_in = '0;
         col_dst_sum_in = '0;
         if (frame_done) begin
            src_row_in     = '0;
            out_row_in     = '0;
            row_src_sum_in = '0;
            row_dst_sum_in = '0;
         end else begin
            if (row_hit) begin
               out_row_in     = cur_out_row + DIM_W'(1);
               row_dst_sum_in = cur_row_dst + SUM_W'(geom.src_h);
            end
            src_row_in     = cur_src_row + POS_W'(1);
            row_src_sum_in = cur_row_src + SUM_W'(geom.dst_h);
         end
      end else begin
         src_col_in     = cur_src_col + POS_W'(1);
         col_src_sum_in = cur_col_src + SUM_W'(geom.dst_w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff     <= '0;
         src_row_ff     <= '0;
         out_col_ff     <= '0;
         out_row_ff     <= '0;
         col_src_sum_ff <= '0;
         col_dst_sum_ff <= '0;
         row_src_sum_ff <= '0;
         row_dst_sum_ff <= '0;
      end else if (accept) begin
         src_col_ff     <= src_col_in;
         src_row_ff     <= src_row_in;
         out_col_ff     <= out_col_in;
         out_row_ff     <= out_row_in;
         col_src_sum_ff <= col_src_sum_in;
         col_dst_sum_ff <= col_dst_sum_in;
         row_src_sum_ff <= row_src_sum_in;
         row_dst_sum_ff <= row_dst_sum_in;
      end
   end

endmodule

/* rtl/nnds_out.sv */
// Result register with a skid stage for the downscaler's output channel.
`timescale 1ns / 1ps

module nnds_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  nnds_pkg::rsp_type push_data,
   output logic              has_room,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nnds_pkg::rsp_type rsp_data
);
   import nnds_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign has_room  = !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;
   assign pop       = main_valid_ff && rsp_ready;

   // Hold order: the skid entry always drains into the main register first
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule
